[sv/rfm_pkg.sv]
`timescale 1ns / 1ps

package rfm_pkg;

  // Frame store and window geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_WINDOW = 7;
  localparam int PIXEL_BITS = 8;

  localparam int MAX_RAD   = MAX_WINDOW / 2;
  localparam int SPAN_MAX  = 2 * MAX_RAD + 1;
  localparam int TAPS_MAX  = SPAN_MAX * SPAN_MAX;
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int IDX_BITS  = (ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS;
  localparam int ADDR_BITS = ROW_BITS + COL_BITS;
  localparam int DEPTH     = MAX_HEIGHT * MAX_WIDTH;
  localparam int RAD_BITS  = $clog2(MAX_RAD + 1);
  localparam int SPAN_BITS = $clog2(SPAN_MAX);
  localparam int CNT_BITS  = $clog2(TAPS_MAX + 1);
  localparam int BIT_BITS  = $clog2(PIXEL_BITS);
  localparam int DIM_BITS  = 7;
  localparam int CRD_BITS  = 9;

  // Boundary modes
  localparam logic [2:0] BM_REFLECT = 3'd0;
  localparam logic [2:0] BM_CONST   = 3'd1;
  localparam logic [2:0] BM_NEAREST = 3'd2;
  localparam logic [2:0] BM_MIRROR  = 3'd3;
  localparam logic [2:0] BM_WRAP    = 3'd4;

  // Rank codes
  localparam logic [1:0] RK_MIN = 2'd0;
  localparam logic [1:0] RK_MED = 2'd1;
  localparam logic [1:0] RK_MAX = 2'd2;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes
  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_WSIZE  = 3'd2;
  localparam logic [2:0] CFG_BMODE  = 3'd3;
  localparam logic [2:0] CFG_FILL   = 3'd4;
  localparam logic [2:0] CFG_RANK   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_ROW,
    ST_MAP_COL,
    ST_TAPS,
    ST_DRAIN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  // Control from the sequencer to the rank selector
  typedef struct packed {
    logic init;
    logic smp_vld;
    logic decide;
  } sel_ctl_t;

endpackage

[sv/image_rank_filter_min_median_max.sv]
`timescale 1ns / 1ps

// Rank filter (min / median / max) over a square window of a stored frame.
//
// Input channel: an item is transferred when start is high and busy is low.
// in_op selects a pixel write (stored, no result) or a query.
// Result channel: out_valid is high for exactly one cycle with out_pixel_out;
// the receiver cannot stall, so each result is taken in that cycle.
// Configuration: cfg_we writes cfg_data to register cfg_index at once; write
// only while busy is low.
// Query sequence, with span S = 2*radius+1: first the S row and S column
// indices are mapped by one shared folding unit, then the window is read
// from the single-port frame memory, one tap a cycle. Min and max take one
// pass over the window. The median is a bitwise radix select, one pass per
// pixel bit. The single read port of the frame memory sets the pace.
// Reset restores the register defaults and idles the sequencer; frame memory
// content is undefined until written.
module image_rank_filter_min_median_max (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_op,
  input  logic [5:0]                      in_row,
  input  logic [5:0]                      in_col,
  input  logic [7:0]                      in_pixel_in,
  output logic                            out_valid,
  output logic [7:0]                      out_pixel_out,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [7:0]                      cfg_data
);
  import rfm_pkg::*;

  // Configuration registers
  logic [DIM_BITS-1:0] fw_r, fh_r;
  logic [2:0]          ws_r, bm_r;
  logic [7:0]          fill_r;
  logic [1:0]          rank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= DIM_BITS'(64);
      fh_r   <= DIM_BITS'(64);
      ws_r   <= 3'd3;
      bm_r   <= BM_REFLECT;
      fill_r <= 8'd0;
      rank_r <= RK_MED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  fw_r   <= cfg_data[DIM_BITS-1:0];
        CFG_HEIGHT: fh_r   <= cfg_data[DIM_BITS-1:0];
        CFG_WSIZE:  ws_r   <= cfg_data[2:0];
        CFG_BMODE:  bm_r   <= cfg_data[2:0];
        CFG_FILL:   fill_r <= cfg_data;
        CFG_RANK:   rank_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Frame size in use and window radius
  logic [DIM_BITS-1:0]  w_use, h_use;
  logic [2:0]           rad_full;
  logic [RAD_BITS-1:0]  rad;
  logic [SPAN_BITS-1:0] span_m1;
  logic [CNT_BITS-1:0]  taps_n, k_med;
  logic                 want_med;

  assign w_use = (fw_r == '0) ? DIM_BITS'(1) :
                 (fw_r > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : fw_r;
  assign h_use = (fh_r == '0) ? DIM_BITS'(1) :
                 (fh_r > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : fh_r;
  assign rad_full = ws_r >> 1;
  assign rad      = (rad_full > 3'(MAX_RAD)) ? RAD_BITS'(MAX_RAD) : RAD_BITS'(rad_full);
  assign span_m1  = SPAN_BITS'({rad, 1'b0});
  assign taps_n   = CNT_BITS'({rad, 1'b1}) * CNT_BITS'({rad, 1'b1});
  assign k_med    = taps_n >> 1;
  assign want_med = !(rank_r == RK_MIN || rank_r == RK_MAX);

  // Sequencer registers
  state_t               state_r, state_nxt;
  logic [ROW_BITS-1:0]  qrow_r, qrow_nxt;
  logic [COL_BITS-1:0]  qcol_r, qcol_nxt;
  logic [SPAN_BITS-1:0] k_r, k_nxt, ta_r, ta_nxt, tb_r, tb_nxt;
  logic [IDX_BITS-1:0]  ridx_r [SPAN_MAX];
  logic [IDX_BITS-1:0]  cidx_r [SPAN_MAX];
  logic [SPAN_MAX-1:0]  rfill_r, cfill_r;
  logic                 vld_d_r, fill_d_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_pix_r, out_pix_nxt;

  // Shared index mapper
  logic                       map_start, map_busy, map_done, map_fill;
  logic [IDX_BITS-1:0]        map_idx;
  logic signed [CRD_BITS-1:0] map_coord;
  logic [DIM_BITS-1:0]        map_dim;
  logic [IDX_BITS-1:0]        base;

  assign base      = (state_r == ST_MAP_ROW) ? IDX_BITS'(qrow_r) : IDX_BITS'(qcol_r);
  assign map_coord = $signed(CRD_BITS'(base)) + $signed(CRD_BITS'(k_r))
                   - $signed(CRD_BITS'(rad));
  assign map_dim   = (state_r == ST_MAP_ROW) ? h_use : w_use;
  assign map_start = (state_r == ST_MAP_ROW || state_r == ST_MAP_COL) && !map_busy;

  rfm_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .start (map_start),
    .coord (map_coord),
    .dim   (map_dim),
    .mode  (bm_r),
    .busy  (map_busy),
    .done  (map_done),
    .idx   (map_idx),
    .fill  (map_fill)
  );

  // Rank selector
  sel_ctl_t             sel_ctl;
  logic [7:0]           smp_val, sel_res, sel_min, sel_max;
  logic                 sel_last;
  logic                 accept;
  logic [7:0]           mem_q_r;

  assign accept  = start && (state_r == ST_IDLE);
  assign smp_val = fill_d_r ? fill_r : mem_q_r;

  rfm_sel u_sel (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sel_ctl),
    .k_in     (k_med),
    .smp_val  (smp_val),
    .result   (sel_res),
    .min_val  (sel_min),
    .max_val  (sel_max),
    .last_bit (sel_last)
  );

  // Frame memory, single port, registered read
  logic [7:0]           mem [DEPTH];
  logic [ADDR_BITS-1:0] rd_addr;
  logic                 wr_en;

  assign rd_addr = {ridx_r[ta_r][ROW_BITS-1:0], cidx_r[tb_r][COL_BITS-1:0]};
  assign wr_en   = accept && (in_op == OP_WRITE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{in_row, in_col}] <= in_pixel_in;
    end else if (state_r == ST_TAPS) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Next state and control
  always_comb begin
    state_nxt     = state_r;
    qrow_nxt      = qrow_r;
    qcol_nxt      = qcol_r;
    k_nxt         = k_r;
    ta_nxt        = ta_r;
    tb_nxt        = tb_r;
    out_valid_nxt = 1'b0;
    out_pix_nxt   = out_pix_r;
    sel_ctl       = '0;
    sel_ctl.smp_vld = vld_d_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_op == OP_QUERY) begin
          qrow_nxt     = ({1'b0, in_row} >= h_use) ? ROW_BITS'(h_use - DIM_BITS'(1)) : in_row;
          qcol_nxt     = ({1'b0, in_col} >= w_use) ? COL_BITS'(w_use - DIM_BITS'(1)) : in_col;
          k_nxt        = '0;
          sel_ctl.init = 1'b1;
          state_nxt    = ST_MAP_ROW;
        end
      end
      ST_MAP_ROW, ST_MAP_COL: begin
        if (map_done) begin
          if (k_r == span_m1) begin
            k_nxt     = '0;
            ta_nxt    = '0;
            tb_nxt    = '0;
            state_nxt = (state_r == ST_MAP_ROW) ? ST_MAP_COL : ST_TAPS;
          end else begin
            k_nxt = k_r + SPAN_BITS'(1);
          end
        end
      end
      ST_TAPS: begin
        if (tb_r == span_m1) begin
          tb_nxt = '0;
          if (ta_r == span_m1) begin
            ta_nxt    = '0;
            state_nxt = ST_DRAIN;
          end else begin
            ta_nxt = ta_r + SPAN_BITS'(1);
          end
        end else begin
          tb_nxt = tb_r + SPAN_BITS'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        sel_ctl.decide = 1'b1;
        priority if (rank_r == RK_MIN) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = sel_min;
          state_nxt     = ST_IDLE;
        end else if (rank_r == RK_MAX) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = sel_max;
          state_nxt     = ST_IDLE;
        end else if (sel_last) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_TAPS;
        end
      end
      ST_FINISH: begin
        out_valid_nxt = 1'b1;
        out_pix_nxt   = sel_res;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_d_r     <= 1'b0;
      k_r         <= '0;
      ta_r        <= '0;
      tb_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vld_d_r     <= (state_r == ST_TAPS);
      k_r         <= k_nxt;
      ta_r        <= ta_nxt;
      tb_r        <= tb_nxt;
    end
    qrow_r    <= qrow_nxt;
    qcol_r    <= qcol_nxt;
    out_pix_r <= out_pix_nxt;
    fill_d_r  <= rfill_r[ta_r] | cfill_r[tb_r];
    if (map_done && state_r == ST_MAP_ROW) begin
      ridx_r[k_r]  <= map_idx;
      rfill_r[k_r] <= map_fill;
    end
    if (map_done && state_r == ST_MAP_COL) begin
      cidx_r[k_r]  <= map_idx;
      cfill_r[k_r] <= map_fill;
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;

  // Checks
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_DECIDE || $past(state_r) == ST_FINISH))
    else $error("result strobe outside a query finish");

  a_map_state: assert property (@(posedge clk) disable iff (!rst_n)
    map_done |-> (state_r == ST_MAP_ROW || state_r == ST_MAP_COL))
    else $error("index mapper finished outside the mapping phase");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (state_r == ST_IDLE && !out_valid_r))
    else $error("pixel write left the idle state");

  a_med_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> want_med)
    else $error("radix finish reached for min or max");

endmodule

[sv/rfm_map.sv]
`timescale 1ns / 1ps

// Axis index mapper: folds or clamps an out-of-range tap index into 0..n-1,
// or marks it as a constant fill tap; one add or subtract of the period per cycle.
module rfm_map (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [rfm_pkg::CRD_BITS-1:0] coord,
  input  logic        [rfm_pkg::DIM_BITS-1:0] dim,
  input  logic        [2:0]                   mode,
  output logic                                busy,
  output logic                                done,
  output logic        [rfm_pkg::IDX_BITS-1:0] idx,
  output logic                                fill
);
  import rfm_pkg::*;

  logic                       busy_r, busy_nxt;
  logic signed [CRD_BITS-1:0] v_r, v_nxt;
  logic signed [CRD_BITS-1:0] n, per, fold;
  logic                       is_mirror, is_wrap;

  assign is_mirror = (mode == BM_MIRROR);
  assign is_wrap   = (mode == BM_WRAP);
  assign n         = $signed({{(CRD_BITS-DIM_BITS){1'b0}}, dim});

  // Period of the fold
  always_comb begin
    priority if (is_wrap) begin
      per = n;
    end else if (is_mirror) begin
      per = (n <<< 1) - CRD_BITS'(2);
    end else begin
      per = n <<< 1;
    end
  end

  assign fold = is_mirror ? ((n <<< 1) - CRD_BITS'(2) - v_r)
                          : ((n <<< 1) - CRD_BITS'(1) - v_r);

  // One reduction step per cycle
  always_comb begin
    busy_nxt = busy_r;
    v_nxt    = v_r;
    done     = 1'b0;
    idx      = '0;
    fill     = 1'b0;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      v_nxt    = coord;
    end else if (busy_r) begin
      priority if (v_r >= 0 && v_r < n) begin
        done = 1'b1;
        idx  = v_r[IDX_BITS-1:0];
      end else if (mode == BM_CONST) begin
        done = 1'b1;
        fill = 1'b1;
      end else if (mode == BM_NEAREST) begin
        done = 1'b1;
        idx  = (v_r < 0) ? '0 : IDX_BITS'(dim - DIM_BITS'(1));
      end else if (is_mirror && dim == DIM_BITS'(1)) begin
        done = 1'b1;
      end else if (v_r < 0) begin
        v_nxt = v_r + per;
      end else if (v_r >= per) begin
        v_nxt = v_r - per;
      end else begin
        done = 1'b1;
        idx  = fold[IDX_BITS-1:0];
      end
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    v_r <= v_nxt;
  end

  assign busy = busy_r;

endmodule

[sv/rfm_sel.sv]
`timescale 1ns / 1ps

// Rank selector: bitwise radix select, one pass over the window per
// result bit, MSB first; min and max tracked on the first pass.
module rfm_sel (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rfm_pkg::sel_ctl_t                     ctl,
  input  logic [rfm_pkg::CNT_BITS-1:0]          k_in,
  input  logic [rfm_pkg::PIXEL_BITS-1:0]        smp_val,
  output logic [rfm_pkg::PIXEL_BITS-1:0]        result,
  output logic [rfm_pkg::PIXEL_BITS-1:0]        min_val,
  output logic [rfm_pkg::PIXEL_BITS-1:0]        max_val,
  output logic                                  last_bit
);
  import rfm_pkg::*;

  logic [PIXEL_BITS-1:0] pre_r, pre_nxt;
  logic [PIXEL_BITS-1:0] min_r, min_nxt, max_r, max_nxt;
  logic [CNT_BITS-1:0]   k_r, k_nxt, cnt_r, cnt_nxt;
  logic [BIT_BITS-1:0]   bit_r, bit_nxt;
  logic                  first_r, first_nxt;
  logic [PIXEL_BITS:0]   ones_sh;
  logic [PIXEL_BITS-1:0] hi_mask;
  logic                  match;

  // Bits above the current one must equal the prefix; current bit zero
  assign ones_sh = {(PIXEL_BITS+1){1'b1}} << ({1'b0, bit_r} + (BIT_BITS+1)'(1));
  assign hi_mask = ones_sh[PIXEL_BITS-1:0];
  assign match   = (((smp_val ^ pre_r) & hi_mask) == '0) && !smp_val[bit_r];

  always_comb begin
    pre_nxt   = pre_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    first_nxt = first_r;
    priority if (ctl.init) begin
      pre_nxt   = '0;
      min_nxt   = '1;
      max_nxt   = '0;
      k_nxt     = k_in;
      cnt_nxt   = '0;
      bit_nxt   = BIT_BITS'(PIXEL_BITS - 1);
      first_nxt = 1'b1;
    end else if (ctl.decide) begin
      if (k_r >= cnt_r) begin
        pre_nxt[bit_r] = 1'b1;
        k_nxt          = k_r - cnt_r;
      end
      cnt_nxt   = '0;
      bit_nxt   = bit_r - BIT_BITS'(1);
      first_nxt = 1'b0;
    end else if (ctl.smp_vld) begin
      if (match) begin
        cnt_nxt = cnt_r + CNT_BITS'(1);
      end
      if (first_r && smp_val < min_r) begin
        min_nxt = smp_val;
      end
      if (first_r && smp_val > max_r) begin
        max_nxt = smp_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r   <= '0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      bit_r   <= bit_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
    end
    pre_r <= pre_nxt;
    min_r <= min_nxt;
    max_r <= max_nxt;
    k_r   <= k_nxt;
  end

  assign result   = pre_r;
  assign min_val  = min_r;
  assign max_val  = max_r;
  assign last_bit = (bit_r == '0);

endmodule

[test/tb_image_rank_filter_min_median_max.sv]
`timescale 1ns / 1ps

module tb_image_rank_filter_min_median_max;
  import rfm_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 600;

  // Frame-store copy, register copy and the queue of pending window results
  class rank_scoreboard;
    bit [7:0] frame [DEPTH];
    bit       written [DEPTH];
    bit [6:0] width_reg, height_reg;
    bit [2:0] wsize_reg, bmode_reg;
    bit [7:0] fill_reg;
    bit [1:0] rank_reg;
    bit [7:0] pending_pixels[$];
    int       errors;

    function new();
      width_reg = 64; height_reg = 64; wsize_reg = 3;
      bmode_reg = BM_REFLECT; fill_reg = 0; rank_reg = RK_MED;
      errors = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [7:0] data);
      case (idx)
        CFG_WIDTH:  width_reg  = data[6:0];
        CFG_HEIGHT: height_reg = data[6:0];
        CFG_WSIZE:  wsize_reg  = data[2:0];
        CFG_BMODE:  bmode_reg  = data[2:0];
        CFG_FILL:   fill_reg   = data;
        CFG_RANK:   rank_reg   = data[1:0];
        default: ;
      endcase
    endfunction

    // Fold an axis index into 0..n-1; -1 marks a constant fill tap
    function int fold_index(int i, int n);
      int m;
      if (i >= 0 && i < n) return i;
      case (bmode_reg)
        BM_CONST:   return -1;
        BM_NEAREST: return (i < 0) ? 0 : n - 1;
        BM_MIRROR: begin
          if (n == 1) return 0;
          m = i % (2 * n - 2);
          if (m < 0) m += 2 * n - 2;
          return (m >= n) ? (2 * n - 2) - m : m;
        end
        BM_WRAP: begin
          m = i % n;
          return (m < 0) ? m + n : m;
        end
        default: begin
          m = i % (2 * n);
          if (m < 0) m += 2 * n;
          return (m >= n) ? (2 * n - 1) - m : m;
        end
      endcase
    endfunction

    function int clamp_dim(int v, int maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    // True when every stored tap of the window has been written
    function bit window_ok(int row, int col);
      int w, h, r, c, rad, ri, ci;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      r = (row >= h) ? h - 1 : row;
      c = (col >= w) ? w - 1 : col;
      rad = wsize_reg / 2;
      if (rad > MAX_RAD) rad = MAX_RAD;
      for (int a = -rad; a <= rad; a++) begin
        for (int b = -rad; b <= rad; b++) begin
          ri = fold_index(r + a, h);
          ci = fold_index(c + b, w);
          if (ri >= 0 && ci >= 0 && !written[ri * MAX_WIDTH + ci]) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function bit [7:0] window_rank(int row, int col);
      int w, h, r, c, rad, ri, ci;
      int taps[$];
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      r = (row >= h) ? h - 1 : row;
      c = (col >= w) ? w - 1 : col;
      rad = wsize_reg / 2;
      if (rad > MAX_RAD) rad = MAX_RAD;
      for (int a = -rad; a <= rad; a++) begin
        for (int b = -rad; b <= rad; b++) begin
          ri = fold_index(r + a, h);
          ci = fold_index(c + b, w);
          if (ri < 0 || ci < 0) taps = {taps, int'(fill_reg)};
          else taps = {taps, int'(frame[ri * MAX_WIDTH + ci])};
        end
      end
      taps.sort();
      case (rank_reg)
        RK_MIN:  return taps[0];
        RK_MAX:  return taps[taps.size() - 1];
        default: return taps[taps.size() / 2];
      endcase
    endfunction

    function void note_transfer(bit op, bit [5:0] row, bit [5:0] col, bit [7:0] pix);
      if (op == OP_WRITE) begin
        frame[row * MAX_WIDTH + col]   = pix;
        written[row * MAX_WIDTH + col] = 1'b1;
      end else begin
        pending_pixels = {pending_pixels, window_rank(row, col)};
      end
    endfunction

    function void check_result(bit [7:0] actual);
      bit [7:0] want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, actual);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (want !== actual) begin
        $display("%0t: pixel_out mismatch, expected %0d, actual %0d", $time, want, actual);
        errors++;
      end
    endfunction
  endclass

  logic       clk, rst_n, start, busy;
  logic       in_op;
  logic [5:0] in_row, in_col;
  logic [7:0] in_pixel_in;
  logic       out_valid;
  logic [7:0] out_pixel_out;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  rank_scoreboard sb = new();
  int idle_pct;
  int quiet_cycles;

  image_rank_filter_min_median_max u_dut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Results cannot be held off: take every strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_pixel_out);
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Coordinates mostly inside the preloaded corner block
  function automatic int pick_coord();
    return ($urandom_range(99) < 75) ? $urandom_range(15) : $urandom_range(63);
  endfunction

  task automatic send_item(bit op, bit [5:0] row, bit [5:0] col, bit [7:0] pix);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1; in_op = op; in_row = row; in_col = col; in_pixel_in = pix;
    do @(posedge clk); while (busy);
    sb.note_transfer(op, row, col, pix);
  endtask

  task automatic fill_block(int r0, int c0, int nr, int nc);
    for (int r = r0; r < r0 + nr; r++)
      for (int c = c0; c < c0 + nc; c++)
        send_item(OP_WRITE, 6'(r), 6'(c), 8'($urandom_range(255)));
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_pixels.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_cfg(bit [2:0] idx, bit [7:0] data);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic apply_setting(bit [7:0] w, bit [7:0] h, bit [7:0] ws, bit [7:0] bm,
                               bit [7:0] fill, bit [7:0] rank);
    drain();
    repeat (20) @(posedge clk);
    write_cfg(CFG_WIDTH, w);
    write_cfg(CFG_HEIGHT, h);
    write_cfg(CFG_WSIZE, ws);
    write_cfg(CFG_BMODE, bm);
    write_cfg(CFG_FILL, fill);
    write_cfg(CFG_RANK, rank);
  endtask

  // Queries only over windows already written; otherwise a write goes out
  task automatic random_items(int count);
    int row, col, tries;
    for (int k = 0; k < count; k++) begin
      row = pick_coord();
      col = pick_coord();
      if ($urandom_range(99) < 55) begin
        tries = 0;
        while (!sb.window_ok(row, col) && tries < 20) begin
          row = pick_coord();
          col = pick_coord();
          tries++;
        end
        if (sb.window_ok(row, col))
          send_item(OP_QUERY, 6'(row), 6'(col), 8'($urandom_range(255)));
        else
          send_item(OP_WRITE, 6'(row), 6'(col), 8'($urandom_range(255)));
      end else begin
        send_item(OP_WRITE, 6'(row), 6'(col), 8'($urandom_range(255)));
      end
    end
  endtask

  // Settings: width, height, window, boundary, fill, rank (extremes and odd codes)
  bit [7:0] settings [10][6] = '{
    '{64, 64, 3, BM_REFLECT, 0, RK_MED},
    '{1, 1, 7, BM_MIRROR, 255, RK_MED},
    '{0, 5, 7, BM_WRAP, 17, RK_MIN},
    '{127, 64, 1, BM_NEAREST, 0, RK_MAX},
    '{8, 3, 5, BM_CONST, 255, 3},
    '{64, 64, 7, 5, 0, RK_MED},
    '{2, 2, 6, BM_REFLECT, 9, RK_MAX},
    '{13, 64, 0, 7, 128, RK_MIN},
    '{64, 1, 4, BM_MIRROR, 1, RK_MED},
    '{37, 29, 7, BM_CONST, 200, RK_MED}
  };
  int idle_plan [3] = '{0, 85, 13};

  initial begin
    rst_n = 1'b0; start = 1'b0; in_op = OP_WRITE; in_row = 0; in_col = 0;
    in_pixel_in = 0; cfg_we = 1'b0; cfg_index = CFG_WIDTH; cfg_data = 0;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Preload the top-left block, the other corners and the centre patch
    fill_block(0, 0, 16, 16);
    fill_block(0, 60, 4, 4);
    fill_block(60, 0, 4, 4);
    fill_block(60, 60, 4, 4);
    fill_block(28, 29, 7, 7);

    // Directed: pixel extremes at the corners, queries at corners with each rank
    send_item(OP_WRITE, 0, 0, 8'd0);
    send_item(OP_WRITE, 63, 63, 8'd255);
    send_item(OP_WRITE, 0, 63, 8'd255);
    send_item(OP_WRITE, 63, 0, 8'd0);
    for (int rk = 0; rk < 3; rk++) begin
      apply_setting(64, 64, 7, rk + 1, 8'hA5, rk);
      send_item(OP_QUERY, 0, 0, 8'hFF);
      send_item(OP_QUERY, 63, 63, 8'h00);
      send_item(OP_QUERY, 0, 63, 8'h5A);
      send_item(OP_QUERY, 63, 0, 8'h00);
      send_item(OP_QUERY, 31, 32, 8'h00);
    end

    // Random phases over the register settings
    for (int p = 0; p < 10; p++) begin
      apply_setting(settings[p][0], settings[p][1], settings[p][2], settings[p][3],
                    settings[p][4], settings[p][5]);
      idle_pct = idle_plan[p % 3];
      if (p == 1) begin
        // sender holds back until every result is home
        for (int k = 0; k < 10; k++) begin
          random_items(3);
          drain();
        end
      end
      random_items(96);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
